>>> hdl/lcdbc_pkg.sv
package lcdbc_pkg;

  // Request codes carried in the cmd field.
  typedef enum logic [2:0] {
    CMD_WRITE_CMD  = 3'd0,
    CMD_WRITE_CHAR = 3'd1,
    CMD_INIT       = 3'd2,
    CMD_SAMPLE     = 3'd3,
    CMD_TICK       = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    STROBE_WRITE = 2'd0,
    STROBE_READ  = 2'd1,
    STROBE_PAUSE = 2'd2
  } strobe_kind_t;

  // Busy-poll phase of the front end.
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WAIT_HI,
    PH_WAIT_LO
  } phase_t;

  // Where the initialise sequence stands.
  typedef enum logic [1:0] {
    STAGE_NONE,
    STAGE_FIRST,
    STAGE_SECOND,
    STAGE_THIRD
  } init_stage_t;

  // Kinds of record run handed from front to back.
  typedef enum logic [1:0] {
    JOB_READ,
    JOB_PAUSE,
    JOB_WRITE,
    JOB_INIT
  } job_kind_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] byte_value;
  } req_t;

  typedef struct packed {
    strobe_kind_t strobe_kind;
    logic         reg_select;
    logic         read_not_write;
    logic [7:0]   bus_value;
    logic [15:0]  delay_after_us;
    logic         failed;
    logic         last;
  } rec_t;

  typedef struct packed {
    logic        four_bit_mode;
    logic [15:0] busy_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] data;
    logic       rs;
    logic       four_bit;
    logic       poll_after;
    logic       failed;
    logic [3:0] last_idx;
  } job_t;

  localparam int unsigned REG_IDX_FOUR_BIT = 0;
  localparam int unsigned REG_IDX_TIMEOUT  = 1;
  localparam logic [15:0] TIMEOUT_RESET    = 16'd1000;
  localparam logic [7:0]  CYR_BASE         = 8'hC0;

  // Character codes from 0xC0 up map through this table.
  localparam logic [7:0] CYR_MAP [64] = '{
    8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'hA4,
    8'hA5, 8'hA6, 8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8,
    8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'hE1, 8'hAB,
    8'hAC, 8'hE2, 8'hAD, 8'hAE, 8'h62, 8'hAF, 8'hB0, 8'hB1,
    8'h61, 8'hB2, 8'hB3, 8'hB4, 8'hE3, 8'h65, 8'hB6, 8'hB7,
    8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE,
    8'h70, 8'h63, 8'hBF, 8'h79, 8'hE4, 8'h78, 8'hE5, 8'hC0,
    8'hC1, 8'hE6, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7
  };

endpackage

>>> hdl/lcdbc_fifo.sv
module lcdbc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hdl/lcdbc_front.sv
module lcdbc_front (
  input  logic              clk,
  input  logic              rst,
  input  lcdbc_pkg::cfg_t   cfg,
  input  logic              accept,
  input  lcdbc_pkg::req_t   req,
  output logic              job_push,
  output lcdbc_pkg::job_t   job
);
  import lcdbc_pkg::*;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_START_CMD,
    ACT_START_INIT,
    ACT_TICK,
    ACT_HIGH_NIBBLE,
    ACT_REPOLL,
    ACT_FINISH_OK,
    ACT_FINISH_FAIL
  } action_t;

  phase_t      phase, phase_next;
  init_stage_t init_stage, init_stage_next;
  logic [7:0]  pending_byte, pending_byte_next;
  logic        pending_rs, pending_rs_next;
  logic [3:0]  high_nibble_seen, high_nibble_seen_next;
  logic [15:0] timeout_count, timeout_count_next;
  logic        failure_flag, failure_flag_next;

  action_t     action;
  logic [7:0]  busy_data;
  logic [7:0]  char_byte;

  assign busy_data = (phase == PH_WAIT_LO) ? {high_nibble_seen, req.byte_value[3:0]}
                                           : req.byte_value;
  assign char_byte = (req.cmd == CMD_WRITE_CHAR && req.byte_value >= CYR_BASE)
                     ? CYR_MAP[req.byte_value[5:0]] : req.byte_value;

  // Classify the accepted request.
  always_comb begin
    action = ACT_NONE;
    if (accept) begin
      if (phase == PH_IDLE) begin
        if (req.cmd == CMD_WRITE_CMD || req.cmd == CMD_WRITE_CHAR) begin
          action = ACT_START_CMD;
        end else if (req.cmd == CMD_INIT) begin
          action = ACT_START_INIT;
        end
      end else if (req.cmd == CMD_TICK) begin
        action = ACT_TICK;
      end else if (req.cmd == CMD_SAMPLE) begin
        if (phase == PH_WAIT_HI && cfg.four_bit_mode) begin
          action = ACT_HIGH_NIBBLE;
        end else if (!busy_data[7]) begin
          action = ACT_FINISH_OK;
        end else if (timeout_count >= cfg.busy_timeout_ticks) begin
          action = ACT_FINISH_FAIL;
        end else begin
          action = ACT_REPOLL;
        end
      end
    end
  end

  // Next state.
  always_comb begin
    phase_next            = phase;
    init_stage_next       = init_stage;
    pending_byte_next     = pending_byte;
    pending_rs_next       = pending_rs;
    high_nibble_seen_next = high_nibble_seen;
    timeout_count_next    = timeout_count;
    failure_flag_next     = failure_flag;
    unique case (action)
      ACT_NONE: begin
      end
      ACT_START_CMD: begin
        pending_rs_next       = req.cmd[0];
        pending_byte_next     = char_byte;
        init_stage_next       = STAGE_NONE;
        timeout_count_next    = '0;
        high_nibble_seen_next = '0;
        phase_next            = PH_WAIT_HI;
      end
      ACT_START_INIT: begin
        failure_flag_next     = 1'b0;
        init_stage_next       = STAGE_FIRST;
        timeout_count_next    = '0;
        high_nibble_seen_next = '0;
        phase_next            = PH_WAIT_HI;
      end
      ACT_TICK: begin
        if (timeout_count != '1) begin
          timeout_count_next = timeout_count + 1'b1;
        end
      end
      ACT_HIGH_NIBBLE: begin
        high_nibble_seen_next = req.byte_value[3:0];
        phase_next            = PH_WAIT_LO;
      end
      ACT_REPOLL: begin
        phase_next = PH_WAIT_HI;
      end
      ACT_FINISH_OK, ACT_FINISH_FAIL: begin
        if (action == ACT_FINISH_FAIL) begin
          failure_flag_next = 1'b1;
        end
        unique case (init_stage)
          STAGE_FIRST: begin
            if (action == ACT_FINISH_OK) begin
              init_stage_next       = STAGE_SECOND;
              timeout_count_next    = '0;
              high_nibble_seen_next = '0;
              phase_next            = PH_WAIT_HI;
            end else begin
              init_stage_next = STAGE_NONE;
              phase_next      = PH_IDLE;
            end
          end
          STAGE_SECOND: begin
            init_stage_next       = STAGE_THIRD;
            timeout_count_next    = '0;
            high_nibble_seen_next = '0;
            phase_next            = PH_WAIT_HI;
          end
          STAGE_THIRD, STAGE_NONE: begin
            init_stage_next = STAGE_NONE;
            phase_next      = PH_IDLE;
          end
          default: begin
            init_stage_next = STAGE_NONE;
            phase_next      = PH_IDLE;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // Run description for the back end.
  always_comb begin
    job_push       = 1'b0;
    job.kind       = JOB_READ;
    job.data       = '0;
    job.rs         = 1'b0;
    job.four_bit   = cfg.four_bit_mode;
    job.poll_after = 1'b0;
    job.failed     = failure_flag_next;
    job.last_idx   = '0;
    unique case (action)
      ACT_NONE, ACT_TICK: begin
      end
      ACT_START_CMD, ACT_HIGH_NIBBLE, ACT_REPOLL: begin
        job_push = 1'b1;
      end
      ACT_START_INIT: begin
        job_push     = 1'b1;
        job.kind     = JOB_INIT;
        job.last_idx = cfg.four_bit_mode ? 4'd13 : 4'd7;
      end
      ACT_FINISH_OK, ACT_FINISH_FAIL: begin
        job_push = 1'b1;
        unique case (init_stage)
          STAGE_FIRST: begin
            if (action == ACT_FINISH_FAIL) begin
              job.kind = JOB_PAUSE;
            end
          end
          STAGE_SECOND: begin
            job.kind       = JOB_WRITE;
            job.data       = 8'h0F;
            job.poll_after = 1'b1;
            job.last_idx   = cfg.four_bit_mode ? 4'd2 : 4'd1;
          end
          STAGE_THIRD: begin
            job.kind     = JOB_WRITE;
            job.data     = 8'h01;
            job.last_idx = cfg.four_bit_mode ? 4'd1 : 4'd0;
          end
          default: begin
            job.kind     = JOB_WRITE;
            job.data     = pending_byte;
            job.rs       = pending_rs;
            job.last_idx = cfg.four_bit_mode ? 4'd1 : 4'd0;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      init_stage       <= STAGE_NONE;
      pending_byte     <= '0;
      pending_rs       <= 1'b0;
      high_nibble_seen <= '0;
      timeout_count    <= '0;
      failure_flag     <= 1'b0;
    end else begin
      phase            <= phase_next;
      init_stage       <= init_stage_next;
      pending_byte     <= pending_byte_next;
      pending_rs       <= pending_rs_next;
      high_nibble_seen <= high_nibble_seen_next;
      timeout_count    <= timeout_count_next;
      failure_flag     <= failure_flag_next;
    end
  end

endmodule

>>> hdl/lcdbc_back.sv
module lcdbc_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            job_empty,
  input  lcdbc_pkg::job_t job,
  output logic            job_pop,
  input  logic            rec_full,
  output logic            rec_push,
  output lcdbc_pkg::rec_t rec
);
  import lcdbc_pkg::*;

  localparam logic [15:0] POWER_UP_US = 16'd40000;

  // Power-up write sequence, one entry per byte.
  function automatic logic [7:0] init_byte(input logic [2:0] i, input logic four);
    case (i)
      3'd0, 3'd1: init_byte = 8'h30;
      3'd2:       init_byte = four ? 8'h28 : 8'h38;
      3'd3:       init_byte = 8'h80;
      3'd4:       init_byte = 8'h01;
      3'd5:       init_byte = 8'h06;
      default:    init_byte = 8'h00;
    endcase
  endfunction

  function automatic logic [15:0] init_delay(input logic [2:0] i);
    case (i)
      3'd0, 3'd1, 3'd3: init_delay = 16'd37;
      3'd4:             init_delay = 16'd2000;
      default:          init_delay = 16'd0;
    endcase
  endfunction

  logic [3:0] k;
  logic       at_last;

  assign at_last  = (k == job.last_idx);
  assign rec_push = !job_empty && !rec_full;
  assign job_pop  = rec_push && at_last;

  always_comb begin
    logic [3:0] j;
    logic [2:0] i;
    logic       hi;
    logic       is_write;
    logic [7:0] b;
    j        = k - 4'd1;
    i        = job.four_bit ? j[3:1] : j[2:0];
    hi       = 1'b0;
    is_write = 1'b0;
    b        = '0;
    rec                = '0;
    rec.strobe_kind    = STROBE_READ;
    rec.read_not_write = 1'b1;
    rec.failed         = job.failed;
    rec.last           = at_last;
    unique case (job.kind)
      JOB_READ: begin
      end
      JOB_PAUSE: begin
        rec.strobe_kind    = STROBE_PAUSE;
        rec.read_not_write = 1'b0;
      end
      JOB_WRITE: begin
        is_write = job.four_bit ? (k <= 4'd1) : (k == 4'd0);
        hi       = job.four_bit && (k == 4'd0);
        if (is_write) begin
          rec.strobe_kind    = STROBE_WRITE;
          rec.read_not_write = 1'b0;
          rec.reg_select     = job.rs;
          rec.bus_value      = hi ? {4'd0, job.data[7:4]}
                             : job.four_bit ? {4'd0, job.data[3:0]} : job.data;
        end
      end
      JOB_INIT: begin
        if (k == 4'd0) begin
          rec.strobe_kind    = STROBE_PAUSE;
          rec.read_not_write = 1'b0;
          rec.delay_after_us = POWER_UP_US;
        end else if (!at_last) begin
          hi                 = job.four_bit && !j[0];
          b                  = init_byte(i, job.four_bit);
          rec.strobe_kind    = STROBE_WRITE;
          rec.read_not_write = 1'b0;
          rec.bus_value      = hi ? {4'd0, b[7:4]}
                             : job.four_bit ? {4'd0, b[3:0]} : b;
          rec.delay_after_us = hi ? 16'd0 : init_delay(i);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (rec_push) begin
      k <= at_last ? 4'd0 : k + 4'd1;
    end
  end

endmodule

>>> hdl/char_lcd_bus_controller.sv
// Channel   Direction  Handshake            Payload
// request   in         push / full          cmd, byte_value
// record    out        pop / empty          strobe_kind .. last (one strobe record)
// config    in         APB psel/penable     four_bit_mode @0x0, busy_timeout_ticks @0x4
//
// The front end takes one request per cycle while its run queue has room and updates
// the busy-poll state in that same cycle. The back end expands each run (1 to 14 records;
// initialise in 4-bit mode is the longest) into strobe records at one per cycle while
// the record queue has room; that sequencer sets the rate. Reset (rst, synchronous)
// empties both queues and restores the register defaults. A full record queue stalls
// only the back end; the front keeps going until the run queue fills, then raises full.
module char_lcd_bus_controller #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  lcdbc_pkg::req_t  request,
  input  logic             pop,
  output logic             empty,
  output lcdbc_pkg::rec_t  record,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import lcdbc_pkg::*;

  cfg_t  cfg;
  logic  cfg_we;
  logic  accept;
  logic  job_push;
  job_t  job_in;
  job_t  job_head;
  logic  job_full;
  logic  job_empty;
  logic  job_pop;
  logic  rec_push;
  logic  rec_full;
  rec_t  rec_in;

  // The register file: the word index is address bit 2.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.four_bit_mode      <= 1'b0;
      cfg.busy_timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      if (paddr[2] == 1'(REG_IDX_FOUR_BIT)) begin
        cfg.four_bit_mode <= pwdata[0];
      end else begin
        cfg.busy_timeout_ticks <= pwdata[15:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == 1'(REG_IDX_TIMEOUT)) begin
      prdata = {16'd0, cfg.busy_timeout_ticks};
    end else begin
      prdata = {31'd0, cfg.four_bit_mode};
    end
  end

  // A request is taken whenever the run queue has room, even while records
  // from earlier requests are still waiting at the output.
  assign full   = job_full;
  assign accept = push && !full;

  lcdbc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .accept   (accept),
    .req      (request),
    .job_push (job_push),
    .job      (job_in)
  );

  lcdbc_fifo #(
    .WIDTH ($bits(job_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_job_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_push),
    .wr_data (job_in),
    .full    (job_full),
    .rd_en   (job_pop),
    .rd_data (job_head),
    .empty   (job_empty)
  );

  lcdbc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_empty (job_empty),
    .job       (job_head),
    .job_pop   (job_pop),
    .rec_full  (rec_full),
    .rec_push  (rec_push),
    .rec       (rec_in)
  );

  // Output queue: parts the record sequencer from the consumer.
  lcdbc_fifo #(
    .WIDTH ($bits(rec_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_rec_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (rec_push),
    .wr_data (rec_in),
    .full    (rec_full),
    .rd_en   (pop),
    .rd_data (record),
    .empty   (empty)
  );

  // Both queues come out of reset empty.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

  // Read strobes release the bus and drive nothing.
  a_read_shape: assert property (@(posedge clk) disable iff (rst)
    (!empty && record.strobe_kind == STROBE_READ) |->
      (record.read_not_write && record.bus_value == 8'd0 &&
       record.delay_after_us == 16'd0 && !record.reg_select))
    else $error("malformed read strobe record");

  // Writes and pauses never raise RW.
  a_write_rw: assert property (@(posedge clk) disable iff (rst)
    (!empty && record.strobe_kind != STROBE_READ) |-> !record.read_not_write)
    else $error("RW high on a write or pause record");

  // A run is only retired from the run queue on its last record.
  a_job_retire: assert property (@(posedge clk) disable iff (rst)
    job_pop |-> (rec_push && rec_in.last))
    else $error("run retired before its last record");

endmodule

>>> test/char_lcd_bus_controller_tb.sv
module char_lcd_bus_controller_tb;
  import lcdbc_pkg::*;

  // Share of cycles in which each side holds off, in percent.
  localparam int unsigned IDLE_PCT = 13;
  // Cycles allowed to pass after the last record before a register write or
  // the final verdict. A run is at most 14 records and the queues are shallow.
  localparam int unsigned SETTLE_CYCLES = 40;
  // Cycles with no transfer on any port before the run is declared hung.
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned MAX_RUN = 16;
  localparam int unsigned ITEMS_PER_PHASE = 48;
  localparam int unsigned N_PHASES = 6;
  localparam int unsigned QUIET_PHASE = 2;

  // Request codes that the block has no use for.
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  localparam logic [2:0] ADDR_FOUR_BIT = 3'(4 * REG_IDX_FOUR_BIT);
  localparam logic [2:0] ADDR_TIMEOUT = 3'(4 * REG_IDX_TIMEOUT);

  // Instruction bytes and delays of the power-up sequence.
  localparam logic [7:0] LCD_WAKE = 8'h30;
  localparam logic [7:0] LCD_FUNC_4BIT = 8'h28;
  localparam logic [7:0] LCD_FUNC_8BIT = 8'h38;
  localparam logic [7:0] LCD_SET_DDRAM = 8'h80;
  localparam logic [7:0] LCD_CLEAR = 8'h01;
  localparam logic [7:0] LCD_ENTRY_MODE = 8'h06;
  localparam logic [7:0] LCD_DISPLAY_ON = 8'h0F;
  localparam logic [15:0] POWER_UP_US = 16'd40000;
  localparam logic [15:0] SHORT_US = 16'd37;
  localparam logic [15:0] CLEAR_US = 16'd2000;

  // Random phases: interface width and busy timeout, extremes among them.
  localparam logic PHASE_MODE [N_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
  localparam logic [15:0] PHASE_TICKS [N_PHASES] =
    '{16'd1, 16'd0, 16'd65535, 16'd3, 16'd2, 16'd1};

  // How a row of the directed table is checked, or whether it reconfigures.
  typedef enum logic [1:0] {
    CHECK_MODEL,
    CHECK_NONE,
    CHECK_ONE,
    SET_CONFIG
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [2:0]  cmd;
    logic [7:0]  value;
    rec_t        want;
    logic        four_bit;
    logic [15:0] ticks;
  } directed_row_t;

  localparam rec_t NO_REC = '0;
  localparam rec_t READ_REC = '{STROBE_READ, 1'b0, 1'b1, 8'h00, 16'd0, 1'b0, 1'b1};
  localparam rec_t WRITE_ZERO_REC = '{STROBE_WRITE, 1'b0, 1'b0, 8'h00, 16'd0, 1'b0, 1'b1};
  localparam rec_t LAST_CYR_REC = '{STROBE_WRITE, 1'b1, 1'b0, 8'hC7, 16'd0, 1'b0, 1'b1};
  localparam rec_t ABORT_REC = '{STROBE_PAUSE, 1'b0, 1'b0, 8'h00, 16'd0, 1'b1, 1'b1};

  // The first part runs with the register values after reset. Typed rows are
  // the ones whose single record is plain to see; the rest go to the predictor.
  localparam int unsigned N_ROWS = 25;
  localparam directed_row_t DIRECTED_ROWS [N_ROWS] = '{
    // Tick, sample and a spare code while idle are all dropped.
    '{CHECK_NONE, CMD_TICK, 8'h00, NO_REC, 1'b0, 16'd0},
    '{CHECK_NONE, CMD_SAMPLE, 8'hFF, NO_REC, 1'b0, 16'd0},
    '{CHECK_NONE, CMD_SPARE_HI, 8'hFF, NO_REC, 1'b0, 16'd0},
    // A command starts a busy poll; new commands are dropped until it ends.
    '{CHECK_ONE, CMD_WRITE_CMD, 8'h00, READ_REC, 1'b0, 16'd0},
    '{CHECK_NONE, CMD_WRITE_CMD, 8'hFF, NO_REC, 1'b0, 16'd0},
    '{CHECK_NONE, CMD_WRITE_CHAR, 8'h55, NO_REC, 1'b0, 16'd0},
    '{CHECK_NONE, CMD_INIT, 8'h00, NO_REC, 1'b0, 16'd0},
    '{CHECK_ONE, CMD_SAMPLE, 8'h80, READ_REC, 1'b0, 16'd0},
    '{CHECK_ONE, CMD_SAMPLE, 8'h7F, WRITE_ZERO_REC, 1'b0, 16'd0},
    // Top of the Cyrillic table, its bottom, and the last code below it.
    '{CHECK_ONE, CMD_WRITE_CHAR, 8'hFF, READ_REC, 1'b0, 16'd0},
    '{CHECK_ONE, CMD_SAMPLE, 8'h00, LAST_CYR_REC, 1'b0, 16'd0},
    '{CHECK_MODEL, CMD_WRITE_CHAR, 8'hC0, NO_REC, 1'b0, 16'd0},
    '{CHECK_MODEL, CMD_SAMPLE, 8'h01, NO_REC, 1'b0, 16'd0},
    '{CHECK_MODEL, CMD_WRITE_CHAR, 8'hBF, NO_REC, 1'b0, 16'd0},
    '{CHECK_MODEL, CMD_SAMPLE, 8'h7E, NO_REC, 1'b0, 16'd0},
    // Full initialise in 8-bit mode through all three waits.
    '{CHECK_MODEL, CMD_INIT, 8'hA5, NO_REC, 1'b0, 16'd0},
    '{CHECK_MODEL, CMD_SAMPLE, 8'hC0, NO_REC, 1'b0, 16'd0},
    '{CHECK_MODEL, CMD_SAMPLE, 8'h00, NO_REC, 1'b0, 16'd0},
    '{CHECK_MODEL, CMD_SAMPLE, 8'h00, NO_REC, 1'b0, 16'd0},
    '{CHECK_MODEL, CMD_SAMPLE, 8'h00, NO_REC, 1'b0, 16'd0},
    // Zero timeout in 4-bit mode: the first busy read aborts initialise, and
    // a command issued after the abort is still written with the failure flag up.
    '{SET_CONFIG, CMD_WRITE_CMD, 8'h00, NO_REC, 1'b1, 16'd0},
    '{CHECK_MODEL, CMD_INIT, 8'h00, NO_REC, 1'b0, 16'd0},
    '{CHECK_MODEL, CMD_SAMPLE, 8'h08, NO_REC, 1'b0, 16'd0},
    '{CHECK_ONE, CMD_SAMPLE, 8'h00, ABORT_REC, 1'b0, 16'd0},
    '{CHECK_MODEL, CMD_WRITE_CMD, 8'h3C, NO_REC, 1'b0, 16'd0}
  };

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  req_t        request;
  logic        pop;
  logic        empty;
  rec_t        record;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  char_lcd_bus_controller dut (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .request (request),
    .pop     (pop),
    .empty   (empty),
    .record  (record),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the block: registers and busy-poll state.
  logic        mode_4bit = 1'b0;
  logic [15:0] timeout_ticks = TIMEOUT_RESET;
  phase_t      poll_phase = PH_IDLE;
  init_stage_t stage = STAGE_NONE;
  logic [7:0]  held_byte = '0;
  logic        held_rs = 1'b0;
  logic [3:0]  hi_nibble = '0;
  logic [15:0] tick_count = '0;
  logic        fail_flag = 1'b0;

  rec_t        step_records[$];
  rec_t        pending_records[$];
  int unsigned n_errors = 0;
  int unsigned idle_pct = IDLE_PCT;

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      n_errors++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
    end
  endfunction

  function automatic void add_record(strobe_kind_t kind, logic rs, logic rw,
                                     logic [7:0] value, logic [15:0] delay);
    rec_t rec;
    if (step_records.size() >= MAX_RUN) return;
    rec = '0;
    rec.strobe_kind = kind;
    rec.reg_select = rs;
    rec.read_not_write = rw;
    rec.bus_value = value;
    rec.delay_after_us = delay;
    step_records.push_back(rec);
  endfunction

  // In 4-bit mode the high nibble goes first and carries no delay.
  function automatic void add_write(logic [7:0] value, logic rs, logic [15:0] delay);
    if (mode_4bit) begin
      add_record(STROBE_WRITE, rs, 1'b0, {4'h0, value[7:4]}, 16'd0);
      add_record(STROBE_WRITE, rs, 1'b0, {4'h0, value[3:0]}, delay);
    end else begin
      add_record(STROBE_WRITE, rs, 1'b0, value, delay);
    end
  endfunction

  function automatic void issue_read();
    add_record(STROBE_READ, 1'b0, 1'b1, 8'h00, 16'd0);
    poll_phase = PH_WAIT_HI;
  endfunction

  function automatic void begin_poll();
    tick_count = '0;
    hi_nibble = '0;
    issue_read();
  endfunction

  function automatic void end_wait(bit ok);
    case (stage)
      STAGE_FIRST: begin
        if (!ok) begin
          add_record(STROBE_PAUSE, 1'b0, 1'b0, 8'h00, 16'd0);
          stage = STAGE_NONE;
          poll_phase = PH_IDLE;
        end else begin
          stage = STAGE_SECOND;
          begin_poll();
        end
      end
      STAGE_SECOND: begin
        add_write(LCD_DISPLAY_ON, 1'b0, 16'd0);
        stage = STAGE_THIRD;
        begin_poll();
      end
      STAGE_THIRD: begin
        add_write(LCD_CLEAR, 1'b0, 16'd0);
        stage = STAGE_NONE;
        poll_phase = PH_IDLE;
      end
      default: begin
        add_write(held_byte, held_rs, 16'd0);
        stage = STAGE_NONE;
        poll_phase = PH_IDLE;
      end
    endcase
  endfunction

  function automatic void busy_result(logic [7:0] status);
    if (!status[7]) begin
      end_wait(1'b1);
    end else if (tick_count >= timeout_ticks) begin
      fail_flag = 1'b1;
      end_wait(1'b0);
    end else begin
      issue_read();
    end
  endfunction

  // Advances the shadow by one request and leaves its records in step_records.
  // Returns whether the request did anything at all.
  function automatic bit predict_request(req_t r);
    bit acted;
    acted = 1'b0;
    step_records.delete();
    if (poll_phase == PH_IDLE) begin
      if (r.cmd == CMD_WRITE_CMD || r.cmd == CMD_WRITE_CHAR) begin
        held_rs = (r.cmd == CMD_WRITE_CHAR);
        held_byte = (held_rs && r.byte_value >= CYR_BASE) ?
                    CYR_MAP[6'(r.byte_value - CYR_BASE)] : r.byte_value;
        stage = STAGE_NONE;
        begin_poll();
        acted = 1'b1;
      end else if (r.cmd == CMD_INIT) begin
        fail_flag = 1'b0;
        add_record(STROBE_PAUSE, 1'b0, 1'b0, 8'h00, POWER_UP_US);
        add_write(LCD_WAKE, 1'b0, SHORT_US);
        add_write(LCD_WAKE, 1'b0, SHORT_US);
        add_write(mode_4bit ? LCD_FUNC_4BIT : LCD_FUNC_8BIT, 1'b0, 16'd0);
        add_write(LCD_SET_DDRAM, 1'b0, SHORT_US);
        add_write(LCD_CLEAR, 1'b0, CLEAR_US);
        add_write(LCD_ENTRY_MODE, 1'b0, 16'd0);
        stage = STAGE_FIRST;
        begin_poll();
        acted = 1'b1;
      end
    end else if (r.cmd == CMD_TICK) begin
      if (tick_count != 16'hFFFF) tick_count++;
      acted = 1'b1;
    end else if (r.cmd == CMD_SAMPLE) begin
      acted = 1'b1;
      if (poll_phase == PH_WAIT_LO) begin
        busy_result({hi_nibble, r.byte_value[3:0]});
      end else if (mode_4bit) begin
        hi_nibble = r.byte_value[3:0];
        add_record(STROBE_READ, 1'b0, 1'b1, 8'h00, 16'd0);
        poll_phase = PH_WAIT_LO;
      end else begin
        busy_result(r.byte_value);
      end
    end
    foreach (step_records[k]) begin
      step_records[k].failed = fail_flag;
      step_records[k].last = (k == step_records.size() - 1);
    end
    return acted;
  endfunction

  // Mostly well-formed traffic: a request while idle, then bus samples and
  // ticks while a wait runs, with some requests that the block must drop.
  function automatic req_t next_random_request();
    req_t r;
    int unsigned roll;
    roll = $urandom_range(99);
    r.byte_value = 8'($urandom_range(255));
    if (poll_phase == PH_IDLE) begin
      if (roll < 45) begin
        r.cmd = CMD_WRITE_CMD;
      end else if (roll < 85) begin
        r.cmd = CMD_WRITE_CHAR;
        if ($urandom_range(1)) r.byte_value = 8'($urandom_range(255, CYR_BASE));
      end else if (roll < 95) begin
        r.cmd = CMD_INIT;
      end else begin
        r.cmd = 3'($urandom_range(CMD_SPARE_HI, CMD_SAMPLE));
      end
    end else begin
      if (roll < 55) r.cmd = CMD_SAMPLE;
      else if (roll < 85) r.cmd = CMD_TICK;
      else if (roll < 95) r.cmd = 3'($urandom_range(CMD_INIT, CMD_WRITE_CMD));
      else r.cmd = 3'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
    end
    return r;
  endfunction

  // Offers one request, waits for it to be taken, and queues what it should
  // produce. push stays high afterwards; the next caller decides its level.
  task automatic send_request(input req_t r, input row_kind_t how, input rec_t want,
                              output bit acted);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    request <= r;
    do @(posedge clk); while (full);
    acted = predict_request(r);
    case (how)
      CHECK_MODEL: foreach (step_records[k]) pending_records.push_back(step_records[k]);
      CHECK_ONE: pending_records.push_back(want);
      default: ;
    endcase
  endtask

  // Setup cycle, then access cycle; psel and penable are left for the caller to drop.
  task automatic apb_access(input logic is_write, input logic [2:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= is_write;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
  endtask

  task automatic verify_registers();
    logic [31:0] value;
    apb_access(1'b0, ADDR_FOUR_BIT, 32'd0, value);
    check_field("four_bit_mode readback", {31'd0, mode_4bit}, value);
    apb_access(1'b0, ADDR_TIMEOUT, 32'd0, value);
    check_field("busy_timeout_ticks readback", {16'd0, timeout_ticks}, value);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Closes any open busy wait with not-busy samples, lets every record drain,
  // then writes both registers and reads them back.
  task automatic reconfigure(input logic four_bit, input logic [15:0] ticks);
    req_t r;
    bit acted;
    logic [31:0] unused;
    while (poll_phase != PH_IDLE) begin
      r.cmd = CMD_SAMPLE;
      r.byte_value = 8'($urandom_range(255)) & 8'h77;
      send_request(r, CHECK_MODEL, NO_REC, acted);
    end
    push <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    apb_access(1'b1, ADDR_FOUR_BIT, {31'd0, four_bit}, unused);
    apb_access(1'b1, ADDR_TIMEOUT, {16'd0, ticks}, unused);
    mode_4bit = four_bit;
    timeout_ticks = ticks;
    verify_registers();
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Record side: pops at random and checks each record against the oldest
  // expectation, field by field.
  initial begin : record_checker
    rec_t got;
    rec_t want;
    pop <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      pop <= ($urandom_range(99) >= idle_pct);
      @(posedge clk);
      if (pop && !empty) begin
        got = record;
        if (pending_records.size() == 0) begin
          n_errors++;
          $display("%0t: record with nothing expected: expected none, got %h", $time, got);
        end else begin
          want = pending_records.pop_front();
          check_field("strobe_kind", 32'(want.strobe_kind), 32'(got.strobe_kind));
          check_field("reg_select", 32'(want.reg_select), 32'(got.reg_select));
          check_field("read_not_write", 32'(want.read_not_write),
                      32'(got.read_not_write));
          check_field("bus_value", 32'(want.bus_value), 32'(got.bus_value));
          check_field("delay_after_us", 32'(want.delay_after_us),
                      32'(got.delay_after_us));
          check_field("failed", 32'(want.failed), 32'(got.failed));
          check_field("last", 32'(want.last), 32'(got.last));
        end
      end
    end
  end

  // Ends the run if no request, record or register access moves for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty) || (psel && penable && pready)) quiet = 0;
      else quiet++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    req_t r;
    bit acted;
    int unsigned sent;
    rst <= 1'b1;
    push <= 1'b0;
    request <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Register values straight out of reset.
    verify_registers();

    // Directed table.
    for (int i = 0; i < N_ROWS; i++) begin
      if (DIRECTED_ROWS[i].kind == SET_CONFIG) begin
        reconfigure(DIRECTED_ROWS[i].four_bit, DIRECTED_ROWS[i].ticks);
      end else begin
        r.cmd = DIRECTED_ROWS[i].cmd;
        r.byte_value = DIRECTED_ROWS[i].value;
        send_request(r, DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].want, acted);
      end
    end

    // Random phases, each under its own register setting; one runs with
    // neither side holding off.
    for (int p = 0; p < N_PHASES; p++) begin
      reconfigure(PHASE_MODE[p], PHASE_TICKS[p]);
      idle_pct = (p == QUIET_PHASE) ? 0 : IDLE_PCT;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        send_request(next_random_request(), CHECK_MODEL, NO_REC, acted);
        sent++;
      end
    end
    idle_pct = IDLE_PCT;

    push <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (n_errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> files.f
hdl/lcdbc_pkg.sv
hdl/lcdbc_fifo.sv
hdl/lcdbc_front.sv
hdl/lcdbc_back.sv
hdl/char_lcd_bus_controller.sv
test/char_lcd_bus_controller_tb.sv
